### hw/rtl/bba_pkg.sv
// Shared codes and constants for the buddy block allocator.
package bba_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam int OUT_W = 17;

endpackage

### hw/rtl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/buddy_block_allocator_core.sv
// Buddy block allocator core: free lists per level, link and level stores in RAM.
//
//   channel | signals                                   | dir | note
//   --------+-------------------------------------------+-----+---------------------------
//   in      | in_valid in_stall operation               | in  | one request, alloc or free
//           | request_bytes address                     |     |
//   out     | out_valid out_stall status result_address | out | one result per request
//           | block_bytes total_bytes peak_bytes        |     |
//
// Allocate does one link RAM read and two link writes per level split. Free
// starts a walk of the free list for every level tried, an entry at a time;
// the single link RAM read port sets this.
// Reset: a clearing pass zeroes every entry of the link and block level stores,
// during which in_stall stays high.
// Stalls: a finished result sits in the output register; the next request is
// taken meanwhile and only its final write of the result waits on out_stall.
module buddy_block_allocator_core
  import bba_pkg::*;
#(
  parameter int MIN_BLOCK_BYTES = 32,
  parameter int NUM_LEVELS      = 12,
  parameter int HEADER_BYTES    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [16:0] request_bytes,
  input  logic [15:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] result_address,
  output logic [16:0] block_bytes,
  output logic [16:0] total_bytes,
  output logic [16:0] peak_bytes
);

  localparam int TOP         = NUM_LEVELS - 1;
  localparam int BW          = NUM_LEVELS - 1;          // block index width
  localparam int POOL_BLOCKS = 1 << BW;
  localparam int LOG_MIN     = $clog2(MIN_BLOCK_BYTES);
  localparam int LIX         = $clog2(NUM_LEVELS);      // level index
  localparam int LVW         = $clog2(NUM_LEVELS + 1);  // stored level + 1
  localparam int BYTEW       = LOG_MIN + NUM_LEVELS;    // holds pool bytes
  localparam int CW          = (BYTEW > 18) ? BYTEW : 18;
  localparam int LKW         = BW + 1;                  // {ok, next block}

  typedef enum logic [16:0] {
    S_CLEAR  = 17'b00000000000000001,
    S_IDLE   = 17'b00000000000000010,
    S_A_DEC  = 17'b00000000000000100,
    S_A_SRCH = 17'b00000000000001000,
    S_S_RD   = 17'b00000000000010000,
    S_S_POP  = 17'b00000000000100000,
    S_S_PUSH = 17'b00000000001000000,
    S_A_RD   = 17'b00000000010000000,
    S_A_POP  = 17'b00000000100000000,
    S_F_CHK  = 17'b00000001000000000,
    S_F_LVRD = 17'b00000010000000000,
    S_F_LV   = 17'b00000100000000000,
    S_W_INIT = 17'b00001000000000000,
    S_W_CHK  = 17'b00010000000000000,
    S_W_DAT  = 17'b00100000000000000,
    S_F_PUSH = 17'b01000000000000000,
    S_DONE   = 17'b10000000000000000
  } state_t;

  state_t state, state_next;

  // request registers
  logic        op_r;
  logic [16:0] req_r;
  logic [15:0] addr_r;

  // list heads, small enough for flops
  logic [BW-1:0] head [NUM_LEVELS];
  logic          head_ok [NUM_LEVELS];

  logic [LIX-1:0] lv, cur_lv, cur_dn;
  logic [BW-1:0]  blk;
  logic [BYTEW-1:0] freed;

  // list walk
  logic [BW-1:0] walk_cur, walk_prev;
  logic          walk_have_prev, walk_valid;
  logic [BW:0]   walk_steps;

  logic [1:0]       res_status;
  logic [15:0]      res_addr;
  logic [BYTEW-1:0] res_bytes;
  logic [BYTEW-1:0] total, peak;
  logic [BW-1:0]    clr_cnt;

  // RAM ports
  logic           lk_we, lv_we;
  logic [BW-1:0]  lk_waddr, lk_raddr, lv_waddr, lv_raddr;
  logic [LKW-1:0] lk_wdata, lk_rdata;
  logic [LVW-1:0] lv_wdata, lv_rdata;

  bba_ram #(.WIDTH(LKW), .DEPTH(POOL_BLOCKS)) u_link_ram (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  bba_ram #(.WIDTH(LVW), .DEPTH(POOL_BLOCKS)) u_level_ram (
    .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .raddr(lv_raddr), .rdata(lv_rdata)
  );

  // ---------------------------------------------------------------
  // Decode helpers
  // ---------------------------------------------------------------
  logic [CW-1:0]  need;
  logic [LIX-1:0] dec_lv, srch_lv;
  logic           dec_fit, srch_found;

  assign need    = CW'(req_r) + CW'(HEADER_BYTES);
  assign dec_fit = need <= (CW'(MIN_BLOCK_BYTES) << TOP);

  // smallest level whose block holds the request
  always_comb begin
    dec_lv = LIX'(TOP);
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (need <= (CW'(MIN_BLOCK_BYTES) << l)) begin
        dec_lv = LIX'(l);
      end
    end
  end

  // lowest non-empty list at or above lv
  always_comb begin
    srch_found = 1'b0;
    srch_lv    = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (LIX'(l) >= lv && head_ok[l]) begin
        srch_found = 1'b1;
        srch_lv    = LIX'(l);
      end
    end
  end

  assign cur_dn = cur_lv - 1'b1;

  // free address checks
  logic [16:0]   off17;
  logic          free_ok;
  logic [BW-1:0] free_blk;

  assign off17    = {1'b0, addr_r} - 17'(HEADER_BYTES);
  assign free_blk = BW'(off17 >> LOG_MIN);
  assign free_ok  = (17'(addr_r) >= 17'(HEADER_BYTES))
                 && ((off17 & 17'(MIN_BLOCK_BYTES - 1)) == '0)
                 && (CW'(off17 >> LOG_MIN) < CW'(POOL_BLOCKS));

  logic [BW-1:0]  b2, buddy;
  logic [LVW-1:0] lv_fetched;
  logic [LIX-1:0] lv_from_ram;
  logic [BYTEW-1:0] sum_total;

  assign b2          = head[cur_lv] + (BW'(1) << cur_dn);
  assign buddy       = blk ^ (BW'(1) << lv);
  assign lv_fetched  = lv_rdata;
  assign lv_from_ram = LIX'(lv_fetched - 1'b1);
  assign sum_total   = total + (BYTEW'(MIN_BLOCK_BYTES) << lv);

  // ---------------------------------------------------------------
  // RAM port muxing
  // ---------------------------------------------------------------
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = '0;
    lk_wdata = '0;
    lk_raddr = walk_cur;
    lv_we    = 1'b0;
    lv_waddr = blk;
    lv_wdata = '0;
    lv_raddr = blk;
    unique case (state)
      S_CLEAR: begin
        // null links and "not allocated" levels
        lk_we    = 1'b1;
        lk_waddr = clr_cnt;
        lv_we    = 1'b1;
        lv_waddr = clr_cnt;
      end
      S_S_RD:  lk_raddr = head[cur_lv];
      S_A_RD:  lk_raddr = head[lv];
      S_S_POP: begin
        lk_we    = 1'b1;
        lk_waddr = b2;
        lk_wdata = {head_ok[cur_dn], head[cur_dn]};
      end
      S_S_PUSH: begin
        lk_we    = 1'b1;
        lk_waddr = blk;
        lk_wdata = {1'b1, head[cur_dn]};
      end
      S_A_POP: begin
        lv_we    = 1'b1;
        lv_waddr = head[lv];
        lv_wdata = LVW'(lv) + 1'b1;
      end
      S_F_LV: begin
        lv_we = (lv_fetched != '0) && (lv_fetched <= LVW'(NUM_LEVELS));
      end
      S_W_DAT: begin
        lk_we    = (walk_cur == buddy) && walk_have_prev;
        lk_waddr = walk_prev;
        lk_wdata = lk_rdata;
      end
      S_F_PUSH: begin
        lk_we    = 1'b1;
        lk_waddr = blk;
        lk_wdata = {head_ok[lv], head[lv]};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) state_next = (operation == OP_ALLOC) ? S_A_DEC : S_F_CHK;
      end
      S_A_DEC:  state_next = dec_fit ? S_A_SRCH : S_DONE;
      S_A_SRCH: begin
        if (!srch_found)        state_next = S_DONE;
        else if (srch_lv > lv)  state_next = S_S_RD;
        else                    state_next = S_A_RD;
      end
      S_S_RD:   state_next = S_S_POP;
      S_S_POP:  state_next = S_S_PUSH;
      S_S_PUSH: state_next = (cur_dn > lv) ? S_S_RD : S_A_RD;
      S_A_RD:   state_next = S_A_POP;
      S_A_POP:  state_next = S_DONE;
      S_F_CHK:  state_next = free_ok ? S_F_LVRD : S_DONE;
      S_F_LVRD: state_next = S_F_LV;
      S_F_LV: begin
        if (lv_fetched == '0 || lv_fetched > LVW'(NUM_LEVELS)) state_next = S_DONE;
        else if (lv_from_ram < LIX'(TOP))                       state_next = S_W_INIT;
        else                                                    state_next = S_F_PUSH;
      end
      S_W_INIT: state_next = S_W_CHK;
      S_W_CHK: begin
        state_next = (walk_valid && walk_steps < (BW+1)'(POOL_BLOCKS)) ? S_W_DAT : S_F_PUSH;
      end
      S_W_DAT: begin
        if (walk_cur == buddy) begin
          state_next = ((lv + 1'b1) < LIX'(TOP)) ? S_W_INIT : S_F_PUSH;
        end else begin
          state_next = S_W_CHK;
        end
      end
      S_F_PUSH: state_next = S_DONE;
      S_DONE:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l]    <= '0;
        head_ok[l] <= (l == TOP);
      end
      total     <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        S_IDLE: begin
          op_r       <= operation;
          req_r      <= request_bytes;
          addr_r     <= address;
          res_status <= ST_OK;
          res_addr   <= '0;
          res_bytes  <= '0;
        end
        S_A_DEC: begin
          lv <= dec_lv;
          if (!dec_fit) res_status <= ST_NOFIT;
        end
        S_A_SRCH: begin
          cur_lv <= srch_lv;
          if (!srch_found) res_status <= ST_NOFIT;
        end
        S_S_POP: begin
          blk             <= head[cur_lv];
          head[cur_lv]    <= lk_rdata[BW-1:0];
          head_ok[cur_lv] <= lk_rdata[BW];
          head[cur_dn]    <= b2;
          head_ok[cur_dn] <= 1'b1;
        end
        S_S_PUSH: begin
          head[cur_dn] <= blk;
          cur_lv       <= cur_dn;
        end
        S_A_POP: begin
          head[lv]    <= lk_rdata[BW-1:0];
          head_ok[lv] <= lk_rdata[BW];
          res_bytes   <= BYTEW'(MIN_BLOCK_BYTES) << lv;
          res_addr    <= 16'((BYTEW'(head[lv]) << LOG_MIN) + BYTEW'(HEADER_BYTES));
          total       <= sum_total;
          if (sum_total > peak) peak <= sum_total;
        end
        S_F_CHK: begin
          blk <= free_blk;
          if (!free_ok) res_status <= ST_BADFREE;
        end
        S_F_LV: begin
          if (lv_fetched == '0 || lv_fetched > LVW'(NUM_LEVELS)) begin
            res_status <= ST_BADFREE;
          end else begin
            lv    <= lv_from_ram;
            freed <= BYTEW'(MIN_BLOCK_BYTES) << lv_from_ram;
          end
        end
        S_W_INIT: begin
          walk_valid     <= head_ok[lv];
          walk_cur       <= head[lv];
          walk_have_prev <= 1'b0;
          walk_steps     <= '0;
        end
        S_W_DAT: begin
          if (walk_cur == buddy) begin
            if (!walk_have_prev) begin
              head[lv]    <= lk_rdata[BW-1:0];
              head_ok[lv] <= lk_rdata[BW];
            end
            if (buddy < blk) blk <= buddy;
            lv <= lv + 1'b1;
          end else begin
            walk_prev      <= walk_cur;
            walk_have_prev <= 1'b1;
            walk_valid     <= lk_rdata[BW];
            walk_cur       <= lk_rdata[BW-1:0];
            walk_steps     <= walk_steps + 1'b1;
          end
        end
        S_F_PUSH: begin
          head[lv]    <= blk;
          head_ok[lv] <= 1'b1;
          res_bytes   <= BYTEW'(MIN_BLOCK_BYTES) << lv;
          total       <= (total >= freed) ? total - freed : '0;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            result_address <= res_addr;
            block_bytes    <= OUT_W'(res_bytes);
            total_bytes    <= OUT_W'(total);
            peak_bytes     <= OUT_W'(peak);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");

  a_peak_ge_total: assert property (@(posedge clk) disable iff (rst) peak >= total)
    else $error("peak below total");

  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall)
    else $error("request taken during clearing pass");

  a_nofit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOFIT |-> block_bytes == '0 && result_address == '0)
    else $error("failed alloc carries a block");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE && (op_r == OP_ALLOC || op_r == OP_FREE))
    else $error("request taken but sequencer idle");

endmodule
